[src/sma_pkg.sv]
// sma_pkg: shared types, register indexes and helpers for the scaled moving average.
// Used by sma_front, sma_queue, sma_back and scaled_moving_average.
package sma_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int SAMPLE_W      = 10;
    localparam int DATA_W        = 16;
    localparam int SHIFT_W       = 5;
    localparam int LEN_CFG_W     = 5;
    localparam int CFG_ADDR_W    = 3;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IN_BIAS    = 3'd0,
        REG_GAIN       = 3'd1,
        REG_GAIN_SHIFT = 3'd2,
        REG_WINDOW_LEN = 3'd3,
        REG_OUT_BIAS   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] in_bias;
        logic signed [DATA_W-1:0] gain;
        logic [SHIFT_W-1:0]       gain_shift;
        logic [LEN_CFG_W-1:0]     window_len;
        logic signed [DATA_W-1:0] out_bias;
    } cfg_t;

    // Clamp a wide signed value to the signed 16-bit range.
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [32:0] v);
        if (v > 33'sd32767)
            return 16'sh7fff;
        else if (v < -33'sd32768)
            return 16'sh8000;
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

[src/scaled_moving_average.sv]
// scaled_moving_average: top level with config registers, front, queue and back.
// Depends on sma_pkg, sma_front, sma_queue and sma_back.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------
//   input   | in_valid / in_stall  | sample (10 bit, unsigned)
//   output  | out_valid / out_stall| average (16 bit, signed)
//   config  | cfg_wr_en            | cfg_addr (3 bit), cfg_wdata (16 bit)
//
// Each sample passes the front multiply register and then the queue; the back
// part handles one item at a time in steps: queue pop, ring write, window sum
// (one ring read a cycle, then the last read drains), a one-bit-per-cycle
// divide over SUM_W = 16 + log2(DEPTH) bits, and the output bias step. It pops
// another item only after the output bias step of the last has finished.
// Reset loads the register defaults and clears the ring valid bits, so unwritten
// entries read as zero; no clearing pass is needed.
// out_stall holds the finished result; the back part waits in its last step,
// while the front stage and a two-entry queue keep taking samples.
module scaled_moving_average #(
    parameter int DEPTH = sma_pkg::DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [sma_pkg::SAMPLE_W-1:0]          sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [sma_pkg::DATA_W-1:0]     average,
    input  logic                                  cfg_wr_en,
    input  logic [sma_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [sma_pkg::DATA_W-1:0]            cfg_wdata
);

    sma_pkg::cfg_t cfg_reg;

    logic                              q_push;
    logic signed [sma_pkg::DATA_W-1:0] q_push_data;
    logic                              q_pop;
    logic signed [sma_pkg::DATA_W-1:0] q_pop_data;
    logic                              q_full;
    logic                              q_empty;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_bias    <= '0;
            cfg_reg.gain       <= 16'sd1;
            cfg_reg.gain_shift <= '0;
            cfg_reg.window_len <= 5'd16;
            cfg_reg.out_bias   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                sma_pkg::REG_IN_BIAS:    cfg_reg.in_bias    <= cfg_wdata;
                sma_pkg::REG_GAIN:       cfg_reg.gain       <= cfg_wdata;
                sma_pkg::REG_GAIN_SHIFT: cfg_reg.gain_shift <= cfg_wdata[sma_pkg::SHIFT_W-1:0];
                sma_pkg::REG_WINDOW_LEN: cfg_reg.window_len <= cfg_wdata[sma_pkg::LEN_CFG_W-1:0];
                sma_pkg::REG_OUT_BIAS:   cfg_reg.out_bias   <= cfg_wdata;
                default:                 ;
            endcase
        end
    end

    // Front: take a transfer, scale it, hand it to the queue.
    sma_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .push      (q_push),
        .push_data (q_push_data),
        .q_full    (q_full)
    );

    sma_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back: update the ring, average the window, present the result.
    sma_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .average   (average)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_fill_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(q_empty) |-> $past(q_push))
        else $error("queue filled without a push");
`endif

endmodule

[src/sma_front.sv]
// sma_front: accepts raw samples, removes the input bias, applies gain and shift.
// Depends on sma_pkg; feeds scaled values into sma_queue.
module sma_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sma_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sma_pkg::SAMPLE_W-1:0]  sample,
    output logic                          push,
    output logic signed [sma_pkg::DATA_W-1:0] push_data,
    input  logic                          q_full
);

    logic signed [16:0] diff;
    logic signed [32:0] prod;
    logic signed [32:0] shifted;
    logic signed [32:0] prod_reg;
    logic               prod_vld_reg;
    logic               accept;

    assign diff    = $signed({7'b0, sample}) - 17'(cfg.in_bias);
    assign prod    = 33'(diff) * 33'(cfg.gain);
    assign shifted = prod_reg >>> cfg.gain_shift;

    assign in_stall  = prod_vld_reg && q_full;
    assign accept    = in_valid && !in_stall;
    assign push      = prod_vld_reg && !q_full;
    assign push_data = sma_pkg::sat16(shifted);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            prod_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                prod_vld_reg <= 1'b1;
                prod_reg     <= prod;
            end
            else if (push)
            begin
                prod_vld_reg <= 1'b0;
            end
        end
    end

endmodule

[src/sma_queue.sv]
// sma_queue: short FIFO of scaled values between the front and back parts.
// Depends on sma_pkg for its depth and data width.
module sma_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic signed [sma_pkg::DATA_W-1:0] push_data,
    input  logic                              pop,
    output logic signed [sma_pkg::DATA_W-1:0] pop_data,
    output logic                              full,
    output logic                              empty
);

    localparam int Q_PTR_W = (sma_pkg::QUEUE_DEPTH > 1) ? $clog2(sma_pkg::QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(sma_pkg::QUEUE_DEPTH + 1);

    logic signed [sma_pkg::DATA_W-1:0] entry_reg [sma_pkg::QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full     = (count_reg == Q_CNT_W'(sma_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        if (p == Q_PTR_W'(sma_pkg::QUEUE_DEPTH - 1))
            return '0;
        else
            return p + Q_PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + Q_CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - Q_CNT_W'(1);
        end
    end

endmodule

[src/sma_back.sv]
// sma_back: ring store, window sum, serial divide and output bias for each value.
// Depends on sma_pkg; takes values from sma_queue, drives the output register.
module sma_back #(
    parameter int DEPTH = sma_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sma_pkg::cfg_t                     cfg,
    input  logic                              q_empty,
    input  logic signed [sma_pkg::DATA_W-1:0] q_data,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [sma_pkg::DATA_W-1:0] average
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int SUM_W = sma_pkg::DATA_W + PTR_W;
    localparam int CNT_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_SUM,
        S_DIV,
        S_POST
    } state_t;

    state_t                            state_reg;
    logic signed [sma_pkg::DATA_W-1:0] ring_mem [DEPTH];
    logic signed [sma_pkg::DATA_W-1:0] new_reg;
    logic signed [sma_pkg::DATA_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]                  vld_reg;
    logic [PTR_W-1:0]                  wp_reg;
    logic [LEN_W-1:0]                  rd_idx_reg;
    logic                              rd_pend_reg;
    logic                              rd_vld_reg;
    logic signed [SUM_W-1:0]           acc_reg;
    logic [SUM_W-1:0]                  dvd_reg;
    logic [LEN_W-1:0]                  rem_reg;
    logic                              neg_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic                              out_valid_reg;
    logic signed [sma_pkg::DATA_W-1:0] average_reg;

    logic [LEN_W-1:0]        len;
    logic [LEN_W-1:0]        wp_inc;
    logic [PTR_W-1:0]        wp_next;
    logic [PTR_W-1:0]        rd_addr;
    logic                    rd_issue;
    logic                    sum_done;
    logic signed [SUM_W-1:0] entry;
    logic [LEN_W:0]          rem_shift;
    logic                    take;
    logic [LEN_W-1:0]        rem_next;
    logic [16:0]             quot;
    logic signed [17:0]      avg;
    logic signed [17:0]      res;
    logic                    out_free;
    logic                    ring_we;

    // Window length clamped to 1 .. DEPTH.
    always_comb
    begin
        if (cfg.window_len == '0)
            len = LEN_W'(1);
        else if (32'(cfg.window_len) > DEPTH)
            len = LEN_W'(DEPTH);
        else
            len = LEN_W'(cfg.window_len);
    end

    assign wp_inc  = LEN_W'(wp_reg) + LEN_W'(1);
    assign wp_next = (wp_inc >= len) ? '0 : PTR_W'(wp_inc);

    assign rd_addr  = rd_idx_reg[PTR_W-1:0];
    assign rd_issue = (state_reg == S_SUM) && (rd_idx_reg < len);
    assign sum_done = (state_reg == S_SUM) && !rd_issue && !rd_pend_reg;
    assign entry    = rd_vld_reg ? SUM_W'(rd_data_reg) : '0;

    // One restoring divide step per cycle.
    assign rem_shift = {rem_reg, dvd_reg[SUM_W-1]};
    assign take      = (rem_shift >= {1'b0, len});
    assign rem_next  = take ? LEN_W'(rem_shift - {1'b0, len}) : rem_shift[LEN_W-1:0];

    assign quot = dvd_reg[16:0];
    assign avg  = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign res  = avg - 18'(cfg.out_bias);

    assign out_free  = !out_valid_reg || !out_stall;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign ring_we   = (state_reg == S_WRITE);
    assign out_valid = out_valid_reg;
    assign average   = average_reg;

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[wp_reg] <= new_reg;
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            new_reg       <= '0;
            vld_reg       <= '0;
            wp_reg        <= '0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
            acc_reg       <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            neg_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            average_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        new_reg   <= q_data;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    vld_reg[wp_reg] <= 1'b1;
                    wp_reg          <= wp_next;
                    rd_idx_reg      <= '0;
                    rd_pend_reg     <= 1'b0;
                    acc_reg         <= '0;
                    state_reg       <= S_SUM;
                end
                S_SUM:
                begin
                    if (rd_issue)
                        rd_idx_reg <= rd_idx_reg + LEN_W'(1);
                    rd_pend_reg <= rd_issue;
                    rd_vld_reg  <= vld_reg[rd_addr];
                    if (rd_pend_reg)
                        acc_reg <= acc_reg + entry;
                    if (sum_done)
                    begin
                        neg_reg   <= acc_reg[SUM_W-1];
                        dvd_reg   <= acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    dvd_reg <= {dvd_reg[SUM_W-2:0], take};
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(SUM_W - 1))
                        state_reg <= S_POST;
                end
                S_POST:
                begin
                    if (out_free)
                    begin
                        average_reg   <= sma_pkg::sat16(33'(res));
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[test/scaled_moving_average_test.sv]
// scaled_moving_average_test: self-checking testbench for the scaled moving average.
// Needs sma_pkg and scaled_moving_average; predicts every average on its own.
`timescale 1ns / 100ps

module scaled_moving_average_test;

    localparam int DEPTH         = sma_pkg::DEPTH_DEFAULT;
    localparam int SAMPLE_W      = sma_pkg::SAMPLE_W;
    localparam int DATA_W        = sma_pkg::DATA_W;
    localparam int SHIFT_W       = sma_pkg::SHIFT_W;
    localparam int LEN_CFG_W     = sma_pkg::LEN_CFG_W;
    localparam int CFG_ADDR_W    = sma_pkg::CFG_ADDR_W;
    localparam int RANDOM_ITEMS  = 900;
    localparam int SETTLE_CYCLES = 64;       // longer than one full-window pass
    localparam int LIMIT_CYCLES  = 400_000;  // many times the slowest legal run
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_FIRST =
        CFG_ADDR_W'(sma_pkg::REG_OUT_BIAS + 1);

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [SAMPLE_W-1:0]      sample    = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] average;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]    cfg_addr  = '0;
    logic [DATA_W-1:0]        cfg_wdata = '0;

    // Shadow copy of the block: registers, ring and write pointer.
    sma_pkg::cfg_t            model_cfg;
    logic signed [DATA_W-1:0] ring_model [DEPTH];
    int unsigned              write_pos_model;

    // Averages predicted for accepted samples, oldest first.
    logic signed [DATA_W-1:0] expected_averages [$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    bit  no_idle     = 1'b0;  // set to run both sides back to back

    scaled_moving_average #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample   (sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .average  (average),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Abort a hung run: no legal run comes anywhere near this count.
    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic signed [DATA_W-1:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[DATA_W-1:0];
    endfunction

    // Advance the shadow ring by one sample and return the average the block must give.
    function automatic logic signed [DATA_W-1:0] predict_average(
        input logic [SAMPLE_W-1:0] s
    );
        int unsigned              len;
        longint                   prod;
        longint                   total;
        logic signed [DATA_W-1:0] scaled;
        // A zero window acts as one entry, an oversized one as the full ring.
        if (model_cfg.window_len == 0)
            len = 1;
        else if (model_cfg.window_len > DEPTH)
            len = DEPTH;
        else
            len = 32'(model_cfg.window_len);
        prod = (longint'(s) - longint'($signed(model_cfg.in_bias)))
             * longint'($signed(model_cfg.gain));
        // Signed shift of a longint floors toward minus infinity.
        prod   = prod >>> model_cfg.gain_shift;
        scaled = clamp16(prod);
        // Write even when the pointer sits past a shrunken window, then wrap.
        ring_model[write_pos_model] = scaled;
        write_pos_model = write_pos_model + 1;
        if (write_pos_model >= len || write_pos_model >= DEPTH)
            write_pos_model = 0;
        total = 0;
        for (int i = 0; i < len; i++)
            total += ring_model[i];
        return clamp16(total / longint'(len) - longint'($signed(model_cfg.out_bias)));
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    function automatic int idle_cycles();
        if (no_idle)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    task automatic apply_reset();
        model_cfg.in_bias    = '0;
        model_cfg.gain       = 16'sd1;
        model_cfg.gain_shift = '0;
        model_cfg.window_len = 5'd16;
        model_cfg.out_bias   = '0;
        foreach (ring_model[i])
            ring_model[i] = '0;
        write_pos_model = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    endtask

    // Write one register; call only with nothing in flight.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            sma_pkg::REG_IN_BIAS:    model_cfg.in_bias    = data;
            sma_pkg::REG_GAIN:       model_cfg.gain       = data;
            sma_pkg::REG_GAIN_SHIFT: model_cfg.gain_shift = data[SHIFT_W-1:0];
            sma_pkg::REG_WINDOW_LEN: model_cfg.window_len = data[LEN_CFG_W-1:0];
            sma_pkg::REG_OUT_BIAS:   model_cfg.out_bias   = data;
            default: ;  // unmapped index: the block drops the write
        endcase
    endtask

    // Offer one sample and hold it until the transfer. Valid stays high on return
    // so a back-to-back sample does not drop and raise it in the same step.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (in_stall);
        expected_averages.push_back(predict_average(value));
    endtask

    // Drop valid and hold off until every predicted average has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_averages.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall per result, compare each transfer in order
    // ------------------------------------------------------------------

    initial
    begin : result_check
        int                       stall_left;
        logic signed [DATA_W-1:0] want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_averages.size() == 0)
                begin
                    $error("average: no transfer expected, actual %0d", average);
                    mismatches++;
                end
                else
                begin
                    want = expected_averages.pop_front();
                    if (average !== want)
                    begin
                        $error("average: expected %0d, actual %0d", want, average);
                        mismatches++;
                    end
                end
                stall_left = idle_cycles();
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            out_stall <= (stall_left != 0);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: unit gain, no biases, a full window over a cleared ring.
    task automatic test_defaults();
        send_sample('0);
        send_sample('1);
        send_sample('1);
        send_sample('0);
        drain_results();
    endtask

    // Drive the scaled value and the output into both clamps, and shift by the maximum.
    task automatic test_saturation();
        write_reg(sma_pkg::REG_IN_BIAS, 16'h8000);
        write_reg(sma_pkg::REG_GAIN, 16'h7fff);
        write_reg(sma_pkg::REG_GAIN_SHIFT, 16'h0000);
        write_reg(sma_pkg::REG_OUT_BIAS, 16'h8000);
        send_sample('1);
        send_sample('0);
        drain_results();
        write_reg(sma_pkg::REG_GAIN, 16'h8000);
        write_reg(sma_pkg::REG_OUT_BIAS, 16'h7fff);
        send_sample('1);
        send_sample(10'd512);
        drain_results();
        // Full shift of a small negative product floors to -1.
        write_reg(sma_pkg::REG_IN_BIAS, 16'd1023);
        write_reg(sma_pkg::REG_GAIN, 16'd1);
        write_reg(sma_pkg::REG_GAIN_SHIFT, 16'hffff);
        write_reg(sma_pkg::REG_OUT_BIAS, 16'h0000);
        send_sample('0);
        send_sample('1);
        drain_results();
    endtask

    // Zero and oversized windows, a pointer left past a shrunken window,
    // and writes to unmapped indexes.
    task automatic test_window_edges();
        int a;
        write_reg(sma_pkg::REG_IN_BIAS, 16'h0000);
        write_reg(sma_pkg::REG_GAIN_SHIFT, 16'h0000);
        write_reg(sma_pkg::REG_WINDOW_LEN, 16'h0000);
        send_sample(10'd5);
        send_sample(10'd1000);
        drain_results();
        write_reg(sma_pkg::REG_WINDOW_LEN, 16'hffff);
        send_sample('1);
        send_sample(10'd7);
        drain_results();
        write_reg(sma_pkg::REG_WINDOW_LEN, 16'd16);
        send_sample(10'd100);
        send_sample(10'd200);
        send_sample(10'd300);
        send_sample(10'd400);
        drain_results();
        // Pointer now sits beyond a window of three.
        write_reg(sma_pkg::REG_WINDOW_LEN, 16'd3);
        send_sample(10'd600);
        send_sample(10'd900);
        drain_results();
        for (a = REG_UNUSED_FIRST; a < (1 << CFG_ADDR_W); a++)
            write_reg(CFG_ADDR_W'(a), 16'hffff);
        send_sample(10'd333);
        drain_results();
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Small signed values half the time, else a clamp extreme or any 16-bit word.
    function automatic logic [DATA_W-1:0] pick_signed(input int span);
        int v;
        case ($urandom_range(0, 3))
            0:       v = $urandom;
            1:       v = $urandom_range(0, 1) ? 32767 : -32768;
            default: v = int'($urandom_range(0, 2 * span)) - span;
        endcase
        return v[DATA_W-1:0];
    endfunction

    // Random upper bits; the five live bits mostly within lo .. hi.
    function automatic logic [DATA_W-1:0] pick_narrow(input int lo, input int hi);
        logic [DATA_W-1:0] d;
        d = DATA_W'($urandom);
        if ($urandom_range(0, 3) == 0)
            d[LEN_CFG_W-1:0] = LEN_CFG_W'($urandom_range(0, 31));
        else
            d[LEN_CFG_W-1:0] = LEN_CFG_W'($urandom_range(lo, hi));
        return d;
    endfunction

    task automatic randomize_config();
        write_reg(sma_pkg::REG_IN_BIAS, pick_signed(1023));
        write_reg(sma_pkg::REG_GAIN, pick_signed(64));
        write_reg(sma_pkg::REG_GAIN_SHIFT, pick_narrow(0, 8));
        write_reg(sma_pkg::REG_WINDOW_LEN, pick_narrow(1, DEPTH));
        write_reg(sma_pkg::REG_OUT_BIAS, pick_signed(512));
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_ADDR_W'($urandom_range(REG_UNUSED_FIRST, (1 << CFG_ADDR_W) - 1)),
                      DATA_W'($urandom));
    endtask

    // Phases of random settings, each a burst of samples; some phases run with
    // no idling, and now and then the sender holds off until all results are in.
    task automatic test_random_stream(input int target);
        int sent;
        int phase_len;
        sent = 0;
        while (sent < target)
        begin
            randomize_config();
            no_idle   = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(8, 60);
            for (int n = 0; n < phase_len; n++)
            begin
                send_sample(random_sample());
                if ($urandom_range(0, 99) == 0)
                    drain_results();
            end
            sent += phase_len;
            drain_results();
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        apply_reset();
        test_defaults();
        test_saturation();
        test_window_edges();
        test_random_stream(RANDOM_ITEMS);
        drain_results();
        // Let any stray extra result surface before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
src/sma_pkg.sv
src/sma_front.sv
src/sma_queue.sv
src/sma_back.sv
src/scaled_moving_average.sv
test/scaled_moving_average_test.sv
